@@ hdl/dtbt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtbt_pkg - shared types and codes for the dirty tile band tracker
// Request action codes, the command word passed from the front end to the
// back end, the result word, and default grid geometry.
// ----------------------------------------------------------------------------
package dtbt_pkg;

  // Default grid geometry
  localparam int DEF_CELLS_ACROSS  = 16;
  localparam int DEF_CELLS_DOWN    = 16;
  localparam int DEF_TILE_PIXELS_W = 8;
  localparam int DEF_TILE_PIXELS_H = 8;

  // Cell indices are carried at the width of the largest supported grid (64)
  localparam int CIDX_W = 6;

  // Depth of the command queue between front and back end
  localparam int CMD_DEPTH = 4;

  // Request action codes
  localparam logic [1:0] ACT_MARK  = 2'd0;
  localparam logic [1:0] ACT_ALL   = 2'd1;
  localparam logic [1:0] ACT_FLUSH = 2'd2;

  // Command kinds seen by the back end
  localparam logic [1:0] CMD_MARK  = 2'd0;
  localparam logic [1:0] CMD_ALL   = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic              force_all;  // flush: mark every cell first
    logic [CIDX_W-1:0] cx0;
    logic [CIDX_W-1:0] cx1;
    logic [CIDX_W-1:0] cy0;
    logic [CIDX_W-1:0] cy1;
  } cmd_t;

  typedef struct packed {
    logic       band_valid;
    logic [3:0] band_row;
    logic [6:0] band_left;
    logic [7:0] band_width;
    logic       last_band;
  } res_t;

endpackage
`default_nettype wire

@@ hdl/dtbt_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtbt_front - request intake and classification
// Two-stage front end: stage A holds the request and forms the far edges,
// stage B clips the rectangle to the window, converts it to cell ranges,
// compares the flush origin and pushes a command into the queue.
// ----------------------------------------------------------------------------
module dtbt_front #(
  parameter int CELLS_ACROSS  = dtbt_pkg::DEF_CELLS_ACROSS,
  parameter int CELLS_DOWN    = dtbt_pkg::DEF_CELLS_DOWN,
  parameter int TILE_PIXELS_W = dtbt_pkg::DEF_TILE_PIXELS_W,
  parameter int TILE_PIXELS_H = dtbt_pkg::DEF_TILE_PIXELS_H
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  output logic                full,
  input  wire  [1:0]          action,
  input  wire  signed [15:0]  rect_x,
  input  wire  signed [15:0]  rect_y,
  input  wire  signed [15:0]  rect_w,
  input  wire  signed [15:0]  rect_h,
  output logic                cmd_push,
  output dtbt_pkg::cmd_t      cmd,
  input  wire                 cmd_full
);
  import dtbt_pkg::*;

  localparam int WIN_W = CELLS_ACROSS * TILE_PIXELS_W;
  localparam int WIN_H = CELLS_DOWN * TILE_PIXELS_H;
  localparam int PXW_X = (WIN_W > 1) ? $clog2(WIN_W) : 1;
  localparam int PXW_Y = (WIN_H > 1) ? $clog2(WIN_H) : 1;
  localparam logic signed [17:0] XMAX = 18'(WIN_W - 1);
  localparam logic signed [17:0] YMAX = 18'(WIN_H - 1);

  // Cell index by reciprocal multiplication; exact for pixel offsets below 4096
  localparam int          RCP_SH = 24;
  localparam logic [24:0] RCP_W  = 25'(((1 << RCP_SH) + TILE_PIXELS_W - 1) / TILE_PIXELS_W);
  localparam logic [24:0] RCP_H  = 25'(((1 << RCP_SH) + TILE_PIXELS_H - 1) / TILE_PIXELS_H);

  function automatic logic [CIDX_W-1:0] cell_of(logic [11:0] px, logic [24:0] rcp);
    logic [36:0] prod;
    prod = 37'(px) * 37'(rcp);
    return prod[RCP_SH +: CIDX_W];
  endfunction

  // Stage A
  logic               a_valid;
  logic [1:0]         a_action;
  logic signed [15:0] a_x, a_y, a_w, a_h;
  // Stage B
  logic               b_valid;
  logic [1:0]         b_action;
  logic signed [15:0] b_x, b_y;
  logic signed [17:0] b_x1, b_y1;
  logic               b_pos;
  // Origin history
  logic [15:0]        prev_x, prev_y;
  logic               seen;

  logic               a_adv, b_adv, b_drop, in_take;
  logic signed [17:0] xl, yl, xr, yr;
  logic               rect_empty;

  assign a_adv   = !b_valid || b_adv;
  assign full    = a_valid && !a_adv;
  assign in_take = push && !full;

  // Clip to the window
  always_comb begin
    xl = b_x[15] ? 18'sd0 : {{2{b_x[15]}}, b_x};
    yl = b_y[15] ? 18'sd0 : {{2{b_y[15]}}, b_y};
    xr = (b_x1 > XMAX) ? XMAX : b_x1;
    yr = (b_y1 > YMAX) ? YMAX : b_y1;
    rect_empty = (xl > xr) || (yl > yr);
  end

  always_comb begin
    case (b_action)
      ACT_MARK:  b_drop = !b_pos || rect_empty;
      ACT_ALL:   b_drop = 1'b0;
      ACT_FLUSH: b_drop = 1'b0;
      default:   b_drop = 1'b1;
    endcase
  end

  assign b_adv    = b_valid && (b_drop || !cmd_full);
  assign cmd_push = b_valid && !b_drop && !cmd_full;

  always_comb begin
    cmd.kind      = CMD_MARK;
    cmd.force_all = 1'b0;
    cmd.cx0       = cell_of(12'(xl[PXW_X-1:0]), RCP_W);
    cmd.cx1       = cell_of(12'(xr[PXW_X-1:0]), RCP_W);
    cmd.cy0       = cell_of(12'(yl[PXW_Y-1:0]), RCP_H);
    cmd.cy1       = cell_of(12'(yr[PXW_Y-1:0]), RCP_H);
    case (b_action)
      ACT_ALL:   cmd.kind = CMD_ALL;
      ACT_FLUSH: begin
        cmd.kind      = CMD_FLUSH;
        cmd.force_all = !seen || (b_x != prev_x) || (b_y != prev_y);
      end
      default:   cmd.kind = CMD_MARK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      seen    <= 1'b0;
      prev_x  <= '0;
      prev_y  <= '0;
    end else begin
      if (in_take) begin
        a_valid  <= 1'b1;
        a_action <= action;
        a_x      <= rect_x;
        a_y      <= rect_y;
        a_w      <= rect_w;
        a_h      <= rect_h;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end

      if (a_adv) begin
        b_valid  <= a_valid;
        b_action <= a_action;
        b_x      <= a_x;
        b_y      <= a_y;
        b_x1     <= {{2{a_x[15]}}, a_x} + {{2{a_w[15]}}, a_w} - 18'sd1;
        b_y1     <= {{2{a_y[15]}}, a_y} + {{2{a_h[15]}}, a_h} - 18'sd1;
        b_pos    <= (a_w > 16'sd0) && (a_h > 16'sd0);
      end

      // record the origin when the flush leaves for the back end
      if (cmd_push && (b_action == ACT_FLUSH)) begin
        seen   <= 1'b1;
        prev_x <= b_x;
        prev_y <= b_y;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/dtbt_cmd_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtbt_cmd_fifo - command queue between front and back end
// Small register queue; the head entry is always presented on cmd_out.
// ----------------------------------------------------------------------------
module dtbt_cmd_fifo (
  input  wire             clk,
  input  wire             rst,
  input  wire             wr,
  input  dtbt_pkg::cmd_t  cmd_in,
  output logic            fifo_full,
  input  wire             rd,
  output dtbt_pkg::cmd_t  cmd_out,
  output logic            fifo_empty
);
  import dtbt_pkg::*;

  localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t             entries [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign fifo_full  = (count == CNT_W'(CMD_DEPTH));
  assign fifo_empty = (count == '0);
  assign do_wr      = wr && !fifo_full;
  assign do_rd      = rd && !fifo_empty;
  assign cmd_out    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/dtbt_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtbt_back - dirty map and flush walker
// Holds one dirty bit per cell and applies mark commands as it pops them; a
// flush walks the rows one per cycle, held on a row while the one-entry
// result register is full, emitting a band per dirty row or one empty report.
// ----------------------------------------------------------------------------
module dtbt_back #(
  parameter int CELLS_ACROSS  = dtbt_pkg::DEF_CELLS_ACROSS,
  parameter int CELLS_DOWN    = dtbt_pkg::DEF_CELLS_DOWN,
  parameter int TILE_PIXELS_W = dtbt_pkg::DEF_TILE_PIXELS_W
) (
  input  wire             clk,
  input  wire             rst,
  input  dtbt_pkg::cmd_t  cmd,
  input  wire             cmd_empty,
  output logic            cmd_pop,
  output dtbt_pkg::res_t  res,
  output logic            res_full,
  input  wire             res_take
);
  import dtbt_pkg::*;

  localparam int   ROW_W   = (CELLS_DOWN > 1) ? $clog2(CELLS_DOWN) : 1;
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic                    state;
  logic [ROW_W-1:0]        cnt;
  logic [CELLS_ACROSS-1:0] rows [CELLS_DOWN];

  logic [CELLS_ACROSS-1:0] cur, colmask;
  logic [CELLS_DOWN-1:0]   nz;
  logic                    later, out_free, emit;
  logic [CIDX_W-1:0]       first, last;
  logic [12:0]             left_px, width_px;
  logic [15:0]             row_ext;

  assign out_free = !res_full || res_take;
  assign cmd_pop  = (state == ST_IDLE) && !cmd_empty;
  assign cur      = rows[cnt];
  assign row_ext  = 16'(cnt);
  // A result is loaded this cycle: a dirty row or the single empty report
  assign emit     = (state == ST_WALK) && out_free && (nz[cnt] || (nz == '0));

  always_comb begin
    for (int j = 0; j < CELLS_ACROSS; j++) begin
      colmask[j] = (CIDX_W'(j) >= cmd.cx0) && (CIDX_W'(j) <= cmd.cx1);
    end
  end

  // Per-row occupancy and whether any dirty row lies below the current one
  always_comb begin
    later = 1'b0;
    for (int i = 0; i < CELLS_DOWN; i++) begin
      nz[i] = |rows[i];
      if (nz[i] && (ROW_W'(i) > cnt)) later = 1'b1;
    end
  end

  // First and last dirty cell of the current row
  always_comb begin
    first = '0;
    last  = '0;
    for (int j = CELLS_ACROSS - 1; j >= 0; j--) begin
      if (cur[j]) first = CIDX_W'(j);
    end
    for (int j = 0; j < CELLS_ACROSS; j++) begin
      if (cur[j]) last = CIDX_W'(j);
    end
    left_px  = 13'(first) * 13'(TILE_PIXELS_W);
    width_px = 13'(7'({1'b0, last}) - 7'({1'b0, first}) + 7'd1) * 13'(TILE_PIXELS_W);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      res_full <= 1'b0;
      for (int i = 0; i < CELLS_DOWN; i++) rows[i] <= '0;
    end else begin
      if (emit) res_full <= 1'b1;
      else if (res_take) res_full <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (cmd_pop) begin
            case (cmd.kind)
              CMD_MARK: begin
                for (int i = 0; i < CELLS_DOWN; i++) begin
                  if ((CIDX_W'(i) >= cmd.cy0) && (CIDX_W'(i) <= cmd.cy1)) begin
                    rows[i] <= rows[i] | colmask;
                  end
                end
              end
              CMD_ALL: begin
                for (int i = 0; i < CELLS_DOWN; i++) rows[i] <= '1;
              end
              CMD_FLUSH: begin
                if (cmd.force_all) begin
                  for (int i = 0; i < CELLS_DOWN; i++) rows[i] <= '1;
                end
                cnt   <= '0;
                state <= ST_WALK;
              end
              default: ;
            endcase
          end
        end
        ST_WALK: begin
          if (nz[cnt]) begin
            if (out_free) begin
              res.band_valid <= 1'b1;
              res.band_row   <= row_ext[3:0];
              res.band_left  <= left_px[6:0];
              res.band_width <= width_px[7:0];
              res.last_band  <= !later;
              rows[cnt]      <= '0;
              if (!later) state <= ST_IDLE;
              else        cnt   <= cnt + 1'b1;
            end
          end else if (nz == '0) begin
            // nothing dirty at all: report one empty band
            if (out_free) begin
              res.band_valid <= 1'b0;
              res.band_row   <= '0;
              res.band_left  <= '0;
              res.band_width <= '0;
              res.last_band  <= 1'b1;
              state          <= ST_IDLE;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/dirty_tile_band_tracker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dirty_tile_band_tracker - dirty cell map with per-row band reporting
// Tracks one dirty bit per screen tile and reports dirty row spans on flush.
// ----------------------------------------------------------------------------
// Requests enter through a queue-style port (push/full) and results leave
// through another (empty/pop). A mark request sets every cell covered by its
// pixel rectangle after clipping to the window; rectangles with a width or
// height of zero or less are dropped. A mark-all request sets every cell. A
// flush request carries the view origin; when it differs from the previous
// one, or on the first flush after reset, every cell is set first. The flush
// then reports one band per dirty row (pixel left edge and width from the
// first to the last dirty cell) and clears that row; last_band flags its
// final result, and a flush that finds nothing dirty returns a single result
// with band_valid low. Action code 3 is ignored. A request passes through
// both front-end stages and waits in a four-entry command queue; the back
// end then applies a mark or mark-all request as it pops it. A flush holds
// the back end while it walks the rows up to the last dirty row, and stalls
// while the result register waits for pop; the row walk is what sets the
// flush time. The front end keeps accepting requests until the command
// queue and both front-end stages fill.
// ----------------------------------------------------------------------------
module dirty_tile_band_tracker #(
  parameter int CELLS_ACROSS  = dtbt_pkg::DEF_CELLS_ACROSS,
  parameter int CELLS_DOWN    = dtbt_pkg::DEF_CELLS_DOWN,
  parameter int TILE_PIXELS_W = dtbt_pkg::DEF_TILE_PIXELS_W,
  parameter int TILE_PIXELS_H = dtbt_pkg::DEF_TILE_PIXELS_H
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  output logic               full,
  input  wire  [1:0]         action,
  input  wire  signed [15:0] rect_x,
  input  wire  signed [15:0] rect_y,
  input  wire  signed [15:0] rect_w,
  input  wire  signed [15:0] rect_h,
  output logic               empty,
  input  wire                pop,
  output logic               band_valid,
  output logic [3:0]         band_row,
  output logic [6:0]         band_left,
  output logic [7:0]         band_width,
  output logic               last_band
);
  import dtbt_pkg::*;

  cmd_t cmd_in, cmd_head;
  logic cmd_push, cmd_pop, cmd_full, cmd_empty;
  res_t res;
  logic res_full, res_take;

  // Accept, clip and classify requests
  dtbt_front #(
    .CELLS_ACROSS  (CELLS_ACROSS),
    .CELLS_DOWN    (CELLS_DOWN),
    .TILE_PIXELS_W (TILE_PIXELS_W),
    .TILE_PIXELS_H (TILE_PIXELS_H)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .action   (action),
    .rect_x   (rect_x),
    .rect_y   (rect_y),
    .rect_w   (rect_w),
    .rect_h   (rect_h),
    .cmd_push (cmd_push),
    .cmd      (cmd_in),
    .cmd_full (cmd_full)
  );

  // Decouple intake from the row walk
  dtbt_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .wr         (cmd_push),
    .cmd_in     (cmd_in),
    .fifo_full  (cmd_full),
    .rd         (cmd_pop),
    .cmd_out    (cmd_head),
    .fifo_empty (cmd_empty)
  );

  // Hold the dirty map, walk rows on flush
  dtbt_back #(
    .CELLS_ACROSS  (CELLS_ACROSS),
    .CELLS_DOWN    (CELLS_DOWN),
    .TILE_PIXELS_W (TILE_PIXELS_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res       (res),
    .res_full  (res_full),
    .res_take  (res_take)
  );

  assign empty      = !res_full;
  assign res_take   = pop && res_full;
  assign band_valid = res.band_valid;
  assign band_row   = res.band_row;
  assign band_left  = res.band_left;
  assign band_width = res.band_width;
  assign last_band  = res.last_band;

`ifndef SYNTHESIS
  // An empty-flush result is always the last result of its flush
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && !band_valid) |-> last_band)
    else $error("empty flush result without last_band");

  // The front end never pushes into a full command queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !cmd_full)
    else $error("command pushed while queue full");

  // The back end only pops a command that is there
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmd_empty)
    else $error("command popped while queue empty");

  // A waiting result that is not taken stays put
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (res_full && !pop) |=> (res_full && $stable(res)))
    else $error("pending result changed before pop");
`endif

endmodule
`default_nettype wire

@@ dv/dirty_tile_band_tracker_test.sv @@
// ----------------------------------------------------------------------------
// dirty_tile_band_tracker_test - self-checking bench for the band tracker
// Drives mark, mark-all, no-op and flush requests through the push/full port,
// keeps its own copy of the dirty cell map and origin, and checks every band
// popped from the empty/pop port against the predicted band list in order.
// ----------------------------------------------------------------------------
module dirty_tile_band_tracker_test;
  import dtbt_pkg::*;

  // Grid geometry of the default build
  localparam int CELLS_X = DEF_CELLS_ACROSS;
  localparam int CELLS_Y = DEF_CELLS_DOWN;
  localparam int TILE_W  = DEF_TILE_PIXELS_W;
  localparam int TILE_H  = DEF_TILE_PIXELS_H;
  localparam int WIN_W   = CELLS_X * TILE_W;
  localparam int WIN_H   = CELLS_Y * TILE_H;

  // The package names three actions; the fourth code is a no-op
  localparam logic [1:0] ACT_NOP = 2'd3;

  // Cycles with no handshake on either side before the run is declared hung
  localparam int QUIET_LIMIT = 4000;
  // Cycles to keep watching once every expected band has arrived
  localparam int SETTLE_CYCLES = 60;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               pop = 1'b0;
  logic [1:0]         action = ACT_MARK;
  logic signed [15:0] rect_x = '0;
  logic signed [15:0] rect_y = '0;
  logic signed [15:0] rect_w = '0;
  logic signed [15:0] rect_h = '0;
  wire                full;
  wire                empty;
  wire                band_valid;
  wire  [3:0]         band_row;
  wire  [6:0]         band_left;
  wire  [7:0]         band_width;
  wire                last_band;

  dirty_tile_band_tracker dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .action     (action),
    .rect_x     (rect_x),
    .rect_y     (rect_y),
    .rect_w     (rect_w),
    .rect_h     (rect_h),
    .empty      (empty),
    .pop        (pop),
    .band_valid (band_valid),
    .band_row   (band_row),
    .band_left  (band_left),
    .band_width (band_width),
    .last_band  (last_band)
  );

  always #5 clk = ~clk;

  // Shadow of the block's state: one dirty bit per cell, last flush origin
  logic [CELLS_X-1:0] dirty_map [CELLS_Y];
  logic [15:0]        last_origin_x;
  logic [15:0]        last_origin_y;
  logic               origin_known;

  // Bands predicted but not yet popped, oldest first
  res_t pending_bands [$];

  int send_idle_pct = 21;
  int recv_idle_pct = 77;
  int err_count = 0;
  int requests_accepted = 0;
  int flushes_accepted = 0;
  int bands_checked = 0;
  int quiet_cycles = 0;

  // Origin that random flushes mostly reuse, so marks show up as real bands
  int cur_origin_x = 0;
  int cur_origin_y = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void set_all_cells();
    for (int r = 0; r < CELLS_Y; r++) dirty_map[r] = '1;
  endfunction

  // Clip the rectangle to the window and set every covered cell. The far
  // edges are formed in int, so a rectangle near +32767 cannot wrap.
  function automatic void mark_cells(logic signed [15:0] x, logic signed [15:0] y,
                                     logic signed [15:0] w, logic signed [15:0] h);
    int x0, y0, x1, y1;
    if (w <= 0 || h <= 0) return;
    x0 = x;
    y0 = y;
    x1 = x0 + w - 1;
    y1 = y0 + h - 1;
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > WIN_W - 1) x1 = WIN_W - 1;
    if (y1 > WIN_H - 1) y1 = WIN_H - 1;
    if (x0 > x1 || y0 > y1) return;
    for (int cy = y0 / TILE_H; cy <= y1 / TILE_H; cy++)
      for (int cx = x0 / TILE_W; cx <= x1 / TILE_W; cx++)
        dirty_map[cy][cx] = 1'b1;
  endfunction

  // Walk the rows top to bottom, queue one band per dirty row and clear it.
  // A clean map still yields one result, flagged last with valid low.
  function automatic void flush_bands(logic [15:0] ox, logic [15:0] oy);
    res_t band;
    int   first, last, found;
    if (!origin_known || ox != last_origin_x || oy != last_origin_y) begin
      last_origin_x = ox;
      last_origin_y = oy;
      origin_known  = 1'b1;
      set_all_cells();
    end
    found = 0;
    for (int r = 0; r < CELLS_Y; r++) begin
      if (dirty_map[r] == '0) continue;
      first = -1;
      last  = -1;
      for (int c = 0; c < CELLS_X; c++) begin
        if (dirty_map[r][c]) begin
          if (first < 0) first = c;
          last = c;
        end
      end
      dirty_map[r] = '0;
      // Hold back the previous band until we know whether it is the last
      if (found > 0) pending_bands.push_back(band);
      band.band_valid = 1'b1;
      band.band_row   = 4'(r);
      band.band_left  = 7'(first * TILE_W);
      band.band_width = 8'((last - first + 1) * TILE_W);
      band.last_band  = 1'b0;
      found++;
    end
    if (found == 0) band = '{band_valid: 1'b0, band_row: '0, band_left: '0,
                             band_width: '0, last_band: 1'b1};
    else band.last_band = 1'b1;
    pending_bands.push_back(band);
  endfunction

  function automatic void predict_request(logic [1:0] act, logic signed [15:0] x,
                                          logic signed [15:0] y, logic signed [15:0] w,
                                          logic signed [15:0] h);
    case (act)
      ACT_MARK:  mark_cells(x, y, w, h);
      ACT_ALL:   set_all_cells();
      ACT_FLUSH: flush_bands(x, y);
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one request, hold it until the block takes it, then predict.
  // Push is left high so a back-to-back request needs no gap; anything that
  // stops sending lowers it first.
  task automatic send_request(logic [1:0] act, int x, int y, int w, int h);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push   <= 1'b1;
    action <= act;
    rect_x <= x[15:0];
    rect_y <= y[15:0];
    rect_w <= w[15:0];
    rect_h <= h[15:0];
    do @(posedge clk); while (full !== 1'b0);
    predict_request(act, x[15:0], y[15:0], w[15:0], h[15:0]);
    requests_accepted++;
    if (act == ACT_FLUSH) flushes_accepted++;
  endtask

  // Drop push and hold off until every predicted band has been popped
  task automatic drain_bands();
    push <= 1'b0;
    @(posedge clk);
    while (pending_bands.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch: %s got %0d want %0d (band %0d)", what, got, want, bands_checked);
    err_count++;
  endtask

  // Randomly stall pop; at 0 percent it stays high
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each popped band with the oldest prediction
  always @(posedge clk) begin : band_checker
    res_t want;
    if (!rst && pop && empty === 1'b0) begin
      if (pending_bands.size() == 0) begin
        report_mismatch("unexpected band, row", band_row, 0);
      end else begin
        want = pending_bands.pop_front();
        if (band_valid !== want.band_valid)
          report_mismatch("band_valid", band_valid, want.band_valid);
        if (band_row !== want.band_row)
          report_mismatch("band_row", band_row, want.band_row);
        if (band_left !== want.band_left)
          report_mismatch("band_left", band_left, want.band_left);
        if (band_width !== want.band_width)
          report_mismatch("band_width", band_width, want.band_width);
        if (last_band !== want.last_band)
          report_mismatch("last_band", last_band, want.last_band);
      end
      bands_checked++;
    end
  end

  // Hang detector: any handshake on either side restarts the count
  always @(posedge clk) begin
    if ((push && full === 1'b0) || (pop && empty === 1'b0)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // The first flush after reset has no origin to compare against, so it must
  // mark everything; repeating the same origin then finds a clean map.
  task automatic test_first_flush();
    send_request(ACT_FLUSH, 0, 0, 0, 0);
    send_request(ACT_FLUSH, 0, 0, -1, -1);
    drain_bands();
  endtask

  // Empty, off-window and clipped rectangles, plus the unused action code
  task automatic test_rect_clipping();
    send_request(ACT_MARK, 10, 10, 0, 5);                      // zero width
    send_request(ACT_MARK, 10, 10, 5, -1);                     // negative height
    send_request(ACT_MARK, -32768, -32768, -32768, -32768);    // all minimum
    send_request(ACT_MARK, -32768, 0, 32767, 8);               // ends left of window
    send_request(ACT_MARK, 32767, 32767, 32767, 32767);        // far edge past 16 bits
    send_request(ACT_MARK, -20, -20, 30, 30);                  // clipped top-left corner
    send_request(ACT_MARK, WIN_W - 1, WIN_H - 1, 1, 1);        // bottom-right pixel
    send_request(ACT_MARK, 60, 40, 1, 1);                      // one interior cell
    send_request(ACT_MARK, -1000, 64, 32767, 1);               // spans the whole row
    send_request(ACT_MARK, 17, 100, 40, 20);                   // straddles three rows
    send_request(ACT_NOP, -1, -1, 32767, 32767);               // must do nothing
    send_request(ACT_FLUSH, 0, 0, 0, 0);
    drain_bands();
  endtask

  task automatic test_mark_all();
    send_request(ACT_ALL, -1, -1, -1, -1);
    send_request(ACT_FLUSH, 0, 0, 32767, -32768);
    drain_bands();
  endtask

  // Origin changes in the top and bottom bits of each coordinate
  task automatic test_origin_compare();
    send_request(ACT_FLUSH, 32'h8000, 0, 0, 0);
    send_request(ACT_FLUSH, 32'h8000, 0, 0, 0);
    send_request(ACT_FLUSH, 32'h8000, 1, 0, 0);
    send_request(ACT_FLUSH, 32'h7fff, 32'hffff, 0, 0);
    send_request(ACT_FLUSH, 32'h7fff, 32'hffff, 0, 0);
    drain_bands();
    cur_origin_x = 32'h7fff;
    cur_origin_y = 32'hffff;
  endtask

  // One random request. Mostly well-formed marks inside or near the window,
  // with flushes often enough that bands pile up; the rest is noise.
  // counts is low for requests that the block simply ignores.
  task automatic random_request(output bit counts);
    int pick, x, y, w, h;
    pick = $urandom_range(99);
    x = $urandom;
    y = $urandom;
    w = $urandom;
    h = $urandom;
    counts = 1'b1;
    if (pick < 58) begin
      x = $urandom_range(WIN_W + 16) - 8;
      y = $urandom_range(WIN_H + 16) - 8;
      w = ($urandom_range(7) == 0) ? $urandom_range(32767, 1) : $urandom_range(40, 1);
      h = ($urandom_range(7) == 0) ? $urandom_range(32767, 1) : $urandom_range(20, 1);
      send_request(ACT_MARK, x, y, w, h);
    end else if (pick < 68) begin
      counts = (w[15:0] != 0 && !w[15] && h[15:0] != 0 && !h[15]);
      send_request(ACT_MARK, x, y, w, h);
    end else if (pick < 73) begin
      send_request(ACT_ALL, x, y, w, h);
    end else if (pick < 77) begin
      counts = 1'b0;
      send_request(ACT_NOP, x, y, w, h);
    end else begin
      // Move the origin now and then; otherwise the flush shows just the marks
      if ($urandom_range(4) == 0) begin
        cur_origin_x = $urandom;
        cur_origin_y = $urandom;
      end
      send_request(ACT_FLUSH, cur_origin_x, cur_origin_y, w, h);
    end
  endtask

  task automatic test_random_traffic(int sender_pct, int receiver_pct, int quota,
                                     bit pause_midway);
    int  done;
    bit  counts;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    done = 0;
    while (done < quota) begin
      random_request(counts);
      if (counts) begin
        done++;
        // Stop feeding until the result side has caught up completely
        if (pause_midway && done == quota / 2) drain_bands();
      end
    end
    drain_bands();
  endtask

  initial begin
    for (int r = 0; r < CELLS_Y; r++) dirty_map[r] = '0;
    last_origin_x = '0;
    last_origin_y = '0;
    origin_known  = 1'b0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_first_flush();
    test_rect_clipping();
    test_mark_all();
    test_origin_compare();
    test_random_traffic(21, 77, 32, 1'b1);
    test_random_traffic(77, 21, 32, 1'b0);
    test_random_traffic(0, 0, 32, 1'b0);

    // Let any late mark settle and catch a stray extra band
    push <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_bands.size() != 0) report_mismatch("bands never popped", 0,
                                                   pending_bands.size());

    $display("covered %0d requests (%0d flushes) with clipping, origin and idle mixes",
             requests_accepted, flushes_accepted);
    $display("checked %0d band results, %0d mismatches", bands_checked, err_count);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
